@@ hdl/bvie_pkg.sv @@
// Shared constants, command codes and cell control type for the bounded vector.
`timescale 1ns / 1ps

package bvie_pkg;

   localparam int DEPTH_DEF     = 64;
   localparam int ELEM_BITS_DEF = 32;

   localparam int CMD_W   = 3;
   localparam int IDX_W   = 7;
   localparam int VAL_W   = 32;
   localparam int CAP_W   = 7;
   localparam int COUNT_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_RESIZE = 3'd5,
      CMD_CLEAR  = 3'd6
   } cmd_type;

   // Per-cycle operation broadcast along the cell row
   typedef struct packed {
      logic ins;   // open a slot at pos, shift later cells up
      logic ers;   // close the slot at pos, shift later cells down
      logic fill;  // write value into slots from count up to pos
   } ctrl_type;

endpackage

@@ hdl/bvie_cell.sv @@
// One storage cell of the element row: holds a word, takes a neighbor's word on shifts.
`timescale 1ns / 1ps

module bvie_cell
   import bvie_pkg::*;
#(
   parameter int POS       = 0,
   parameter int ELEM_BITS = ELEM_BITS_DEF,
   parameter int CMP_W     = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   input  logic [CMP_W-1:0]     pos,
   input  logic [CMP_W-1:0]     cnt,
   input  logic [ELEM_BITS-1:0] value,
   input  logic [ELEM_BITS-1:0] left_elem,
   input  logic [ELEM_BITS-1:0] right_elem,
   output logic [ELEM_BITS-1:0] elem,
   output logic [ELEM_BITS-1:0] rd_elem
);

   localparam logic [CMP_W-1:0] POS_C  = CMP_W'(POS);
   localparam logic [CMP_W-1:0] POS_N1 = CMP_W'(POS + 1);

   logic [ELEM_BITS-1:0] elem_ff;
   logic [ELEM_BITS-1:0] elem_in;

   always_comb begin
      elem_in = elem_ff;
      if (ctrl.ins) begin
         if (POS_C == pos) begin
            elem_in = value;
         end else if (POS_C > pos && POS_C <= cnt) begin
            elem_in = left_elem;
         end
      end else if (ctrl.ers) begin
         if (POS_C >= pos && POS_N1 < cnt) begin
            elem_in = right_elem;
         end
      end else if (ctrl.fill) begin
         if (POS_C >= cnt && POS_C < pos) begin
            elem_in = value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff <= '0;
      end else begin
         elem_ff <= elem_in;
      end
   end

   assign elem    = elem_ff;
   // gate onto the shared read bus only when addressed
   assign rd_elem = (POS_C == pos) ? elem_ff : '0;

endmodule

@@ hdl/bounded_vector_insert_erase.sv @@
// Top level of the bounded vector: command decode, count, cell row and result register.
`timescale 1ns / 1ps
//
// Bounded ordered list of up to DEPTH elements held in a row of register cells.
// Request words (req_*) carry one command each: push, pop, insert, erase, read,
// resize or clear. Each accepted word yields exactly one response word (rsp_*)
// with ok, the data popped, erased or read, the new count and empty/full flags.
// A command that hits a bound (full, empty, index out of range, size above
// capacity) returns ok 0 and leaves the list unchanged.
// The response is registered at the edge that accepts the request. Throughput is
// one word per cycle while the receiver keeps up; insert and erase shift every
// later cell in that same edge, and reads go through one OR tree over the row.
// The response register frees while it is being taken, so a new request is
// accepted whenever the response is empty or rsp_tready is high; a stalled
// receiver holds the response and stalls the request side.
// csr_wen/csr_wdata write the capacity register; write it only while idle.
// Synchronous reset empties the list, zeroes all cells and sets capacity to 64.
//
module bounded_vector_insert_erase
   import bvie_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [6:0]   csr_wdata,    // capacity
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,    // index[6:0], value[38:7], fill_valid[39]
   input  logic [2:0]   req_tuser,    // cmd[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata     // ok[0], data[32:1], count[39:33],
                                      // empty_res[40], full_res[41], zero above
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
   localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

   // Capacity register
   logic [CAP_W-1:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wen) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Request fields
   logic [CMD_W-1:0]     req_cmd;
   logic [IDX_W-1:0]     req_index;
   logic [VAL_W-1:0]     req_value;
   logic                 req_fill;
   logic [ELEM_BITS+VAL_W-1:0] value_wide;
   logic [ELEM_BITS-1:0] value_elem;

   assign req_cmd    = req_tuser;
   assign req_index  = req_tdata[6:0];
   assign req_value  = req_tdata[38:7];
   assign req_fill   = req_tdata[39];
   assign value_wide = {{ELEM_BITS{1'b0}}, req_value};
   assign value_elem = value_wide[ELEM_BITS-1:0];

   logic accept;
   assign accept = req_tvalid && req_tready;

   // Count and decode
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] n_ext;
   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] pos;
   logic [CMP_W-1:0] n_next;
   logic             ok_in;
   logic             rd_use;
   ctrl_type         ctrl;

   assign n_ext   = CMP_W'(count_ff);
   assign idx_ext = CMP_W'(req_index);
   assign cap_ext = CMP_W'(capacity_ff);
   assign cap_eff = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;

   always_comb begin
      pos    = idx_ext;
      n_next = n_ext;
      ok_in  = 1'b0;
      rd_use = 1'b0;
      ctrl   = '0;
      case (req_cmd)
         CMD_PUSH: begin
            pos = n_ext;
            if (n_ext < cap_eff) begin
               ok_in    = 1'b1;
               ctrl.ins = 1'b1;
               n_next   = n_ext + ONE_C;
            end
         end
         CMD_POP: begin
            pos = n_ext - ONE_C;
            if (n_ext != '0) begin
               ok_in  = 1'b1;
               rd_use = 1'b1;
               n_next = n_ext - ONE_C;
            end
         end
         CMD_INSERT: begin
            if (n_ext < cap_eff && idx_ext <= n_ext) begin
               ok_in    = 1'b1;
               ctrl.ins = 1'b1;
               n_next   = n_ext + ONE_C;
            end
         end
         CMD_ERASE: begin
            if (idx_ext < n_ext) begin
               ok_in    = 1'b1;
               rd_use   = 1'b1;
               ctrl.ers = 1'b1;
               n_next   = n_ext - ONE_C;
            end
         end
         CMD_READ: begin
            if (idx_ext < n_ext) begin
               ok_in  = 1'b1;
               rd_use = 1'b1;
            end
         end
         CMD_RESIZE: begin
            if (idx_ext <= cap_eff) begin
               ok_in     = 1'b1;
               ctrl.fill = req_fill;
               n_next    = idx_ext;
            end
         end
         CMD_CLEAR: begin
            ok_in  = 1'b1;
            n_next = '0;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // Drop the operation unless a word is actually taken
   ctrl_type cell_ctrl;
   assign cell_ctrl = accept ? ctrl : '0;
   assign count_in  = accept ? n_next[CNT_W-1:0] : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Cell row
   logic [ELEM_BITS-1:0] elem_row [DEPTH];
   logic [ELEM_BITS-1:0] rd_row   [DEPTH];

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [ELEM_BITS-1:0] left_w;
      logic [ELEM_BITS-1:0] right_w;
      if (gi == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = elem_row[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = elem_row[gi+1];
      end
      bvie_cell #(
         .POS       (gi),
         .ELEM_BITS (ELEM_BITS),
         .CMP_W     (CMP_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .pos        (pos),
         .cnt        (n_ext),
         .value      (value_elem),
         .left_elem  (left_w),
         .right_elem (right_w),
         .elem       (elem_row[gi]),
         .rd_elem    (rd_row[gi])
      );
   end

   // Read bus: at most one cell drives a nonzero word
   logic [ELEM_BITS-1:0] rd_bus;
   always_comb begin
      rd_bus = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_bus = rd_bus | rd_row[k];
      end
   end

   logic [ELEM_BITS+VAL_W-1:0] rd_wide;
   logic [VAL_W-1:0]           data_in;
   assign rd_wide = {{VAL_W{1'b0}}, rd_bus};
   assign data_in = rd_use ? rd_wide[VAL_W-1:0] : '0;

   // Response register
   logic         rsp_valid_ff;
   logic [47:0]  rsp_data_ff;
   logic [47:0]  rsp_data_in;

   assign rsp_data_in = {6'b0,
                         (n_next >= cap_eff),
                         (n_next == '0),
                         n_next[COUNT_W-1:0],
                         data_in,
                         ok_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= DEPTH_C)
      else $error("element count above depth");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && !ok_in |=> $stable(count_ff))
      else $error("rejected command changed the count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_CLEAR |=> count_ff == '0)
      else $error("clear left elements");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tdata[39:33] == COUNT_W'(count_ff) && rsp_tdata[40] == (count_ff == '0))
      else $error("response count disagrees with state");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the bounded vector: directed and random list commands, scoreboarded.
`timescale 1ns / 1ps

module testbench;
   import bvie_pkg::*;

   // 3-bit command code that the block must reject
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;
   localparam int unsigned LONG_HOLD_CYCLES = 200;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
      logic             fill;
   } list_op_type;

   typedef struct {
      logic               ok;
      logic [VAL_W-1:0]   data;
      logic [COUNT_W-1:0] count;
      logic               empty;
      logic               full;
   } list_reply_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [6:0]  csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // index[6:0], value[38:7], fill_valid[39]
   logic [2:0]  req_tuser  = '0;   // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // ok[0], data[32:1], count[39:33], empty_res[40],
                                   // full_res[41]

   list_op_type    pending_list_ops[$];
   list_reply_type predicted_replies[$];

   // Shadow of the list held by the block
   logic [VAL_W-1:0] store_model[DEPTH_DEF];
   int unsigned      count_model;
   int unsigned      capacity_model;

   int unsigned mismatches      = 0;
   logic        req_word_taken  = 1'b0;
   logic        idling_on       = 1'b1;
   int unsigned req_gap_left    = 0;
   int unsigned rsp_stall_left  = 0;
   int unsigned long_hold_asks  = 0;
   int unsigned long_hold_seen  = 0;
   int unsigned long_hold_left  = 0;

   bounded_vector_insert_erase dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Apply one command to the shadow list and return the reply it must give
   function automatic list_reply_type apply_list_op(list_op_type op);
      int unsigned eff_cap;
      int unsigned n;
      int unsigned i;
      list_reply_type r;
      eff_cap = (capacity_model > DEPTH_DEF) ? DEPTH_DEF : capacity_model;
      n = count_model;
      r.ok = 1'b0;
      r.data = '0;
      case (op.cmd)
         CMD_PUSH: begin
            if (n < eff_cap) begin
               store_model[n] = op.value;
               count_model = n + 1;
               r.ok = 1'b1;
            end
         end
         CMD_POP: begin
            if (n > 0) begin
               r.data = store_model[n-1];
               count_model = n - 1;
               r.ok = 1'b1;
            end
         end
         CMD_INSERT: begin
            if (n < eff_cap && op.index <= n) begin
               for (i = n; i > op.index; i--) store_model[i] = store_model[i-1];
               store_model[op.index] = op.value;
               count_model = n + 1;
               r.ok = 1'b1;
            end
         end
         CMD_ERASE: begin
            if (op.index < n) begin
               r.data = store_model[op.index];
               for (i = op.index; i + 1 < n; i++) store_model[i] = store_model[i+1];
               count_model = n - 1;
               r.ok = 1'b1;
            end
         end
         CMD_READ: begin
            if (op.index < n) begin
               r.data = store_model[op.index];
               r.ok = 1'b1;
            end
         end
         CMD_RESIZE: begin
            if (op.index <= eff_cap) begin
               if (op.fill)
                  for (i = n; i < op.index; i++) store_model[i] = op.value;
               count_model = op.index;
               r.ok = 1'b1;
            end
         end
         CMD_CLEAR: begin
            count_model = 0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.count = COUNT_W'(count_model);
      r.empty = (count_model == 0);
      r.full  = (count_model >= eff_cap);
      return r;
   endfunction

   function automatic list_op_type random_list_op(int unsigned cap_setting);
      list_op_type op;
      int unsigned pick;
      int unsigned span;
      span = (cap_setting > DEPTH_DEF) ? DEPTH_DEF : cap_setting;
      pick = $urandom_range(0, 99);
      if (pick < 26)      op.cmd = CMD_PUSH;
      else if (pick < 40) op.cmd = CMD_POP;
      else if (pick < 60) op.cmd = CMD_INSERT;
      else if (pick < 74) op.cmd = CMD_ERASE;
      else if (pick < 88) op.cmd = CMD_READ;
      else if (pick < 96) op.cmd = CMD_RESIZE;
      else if (pick < 98) op.cmd = CMD_CLEAR;
      else                op.cmd = CMD_UNKNOWN;
      // keep most positions near the live range, some anywhere in the field
      if ($urandom_range(0, 9) < 8) op.index = IDX_W'($urandom_range(0, span + 1));
      else                          op.index = IDX_W'($urandom_range(0, 127));
      case ($urandom_range(0, 9))
         0:       op.value = '0;
         1:       op.value = '1;
         default: op.value = $urandom;
      endcase
      op.fill = 1'($urandom_range(0, 1));
      return op;
   endfunction

   task automatic compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic add_op(logic [CMD_W-1:0] cmd, int unsigned index, logic [VAL_W-1:0] value,
                         logic fill);
      list_op_type op;
      op.cmd   = cmd;
      op.index = IDX_W'(index);
      op.value = value;
      op.fill  = fill;
      pending_list_ops.push_back(op);
   endtask

   // Look only after the driver's updates at this edge have settled
   task automatic wait_list_idle();
      #1;
      while (pending_list_ops.size() != 0 || req_tvalid || predicted_replies.size() != 0) begin
         @(negedge clock);
         #1;
      end
   endtask

   task automatic write_capacity(logic [6:0] cap);
      csr_wen   <= 1'b1;
      csr_wdata <= cap;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Request driver: hold the word until taken, then advance
   always @(negedge clock) begin : drive_requests
      list_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_word_taken)) begin
         if (req_gap_left > 0) begin
            req_gap_left <= req_gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_list_ops.size() > 0) begin
            op = pending_list_ops.pop_front();
            req_tuser  <= op.cmd;
            req_tdata  <= {op.fill, op.value, op.index};
            req_tvalid <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0)
               req_gap_left <= $urandom_range(1, 16);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_hold_seen != long_hold_asks) begin
         long_hold_seen <= long_hold_asks;
         long_hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_stall_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on each request word, check each response word
   always @(posedge clock) begin : watch_ports
      list_reply_type got;
      list_reply_type want;
      list_op_type    op;
      if (reset) begin
         for (int i = 0; i < DEPTH_DEF; i++) store_model[i] = '0;
         count_model    = 0;
         capacity_model = CAP_RESET;
         predicted_replies.delete();
         req_word_taken <= 1'b0;
      end else begin
         req_word_taken <= req_tvalid && req_tready;
         if (csr_wen) capacity_model = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.ok    = rsp_tdata[0];
            got.data  = rsp_tdata[32:1];
            got.count = rsp_tdata[39:33];
            got.empty = rsp_tdata[40];
            got.full  = rsp_tdata[41];
            if (predicted_replies.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = predicted_replies.pop_front();
               compare_field("ok", want.ok, got.ok);
               compare_field("data", want.data, got.data);
               compare_field("count", want.count, got.count);
               compare_field("empty_res", want.empty, got.empty);
               compare_field("full_res", want.full, got.full);
            end
         end
         if (req_tvalid && req_tready) begin
            op.cmd   = req_tuser;
            op.index = req_tdata[6:0];
            op.value = req_tdata[38:7];
            op.fill  = req_tdata[39];
            predicted_replies.push_back(apply_list_op(op));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : run_phases
      logic [6:0] cap_settings[10];
      cap_settings = '{7'd127, 7'd0, 7'd1, 7'd2, 7'd65, 7'd63, 7'd10, 7'd33, 7'd64, 7'd64};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_capacity(7'd64);

      // empty-list rejections, bounds and shifting
      add_op(CMD_POP,     0,   32'h0,        1'b0);
      add_op(CMD_READ,    0,   32'h0,        1'b0);
      add_op(CMD_ERASE,   0,   32'h0,        1'b0);
      add_op(CMD_UNKNOWN, 127, 32'hFFFFFFFF, 1'b1);
      add_op(CMD_CLEAR,   0,   32'h0,        1'b0);
      add_op(CMD_PUSH,    0,   32'hFFFFFFFF, 1'b0);
      add_op(CMD_PUSH,    0,   32'h0,        1'b0);
      add_op(CMD_INSERT,  0,   32'hA5A5A5A5, 1'b0);
      add_op(CMD_INSERT,  3,   32'h12345678, 1'b0);
      add_op(CMD_INSERT,  127, 32'h0BADF00D, 1'b0);
      add_op(CMD_READ,    0,   32'h0,        1'b0);
      add_op(CMD_READ,    127, 32'h0,        1'b0);
      add_op(CMD_ERASE,   1,   32'h0,        1'b0);
      add_op(CMD_ERASE,   3,   32'h0,        1'b0);
      add_op(CMD_RESIZE,  10,  32'h5A5A5A5A, 1'b1);
      add_op(CMD_RESIZE,  70,  32'h0,        1'b1);
      add_op(CMD_RESIZE,  64,  32'hFFFFFFFF, 1'b0);
      add_op(CMD_PUSH,    0,   32'h11111111, 1'b0);
      add_op(CMD_INSERT,  0,   32'h22222222, 1'b0);
      add_op(CMD_RESIZE,  2,   32'h0,        1'b0);
      add_op(CMD_RESIZE,  5,   32'h0,        1'b0);
      add_op(CMD_READ,    4,   32'h0,        1'b0);
      add_op(CMD_POP,     0,   32'h0,        1'b0);
      add_op(CMD_RESIZE,  40,  32'h0F0F0F0F, 1'b1);
      wait_list_idle();

      // capacity dropped below the count: contents stay reachable
      write_capacity(7'd5);
      add_op(CMD_PUSH,    0,  32'h33333333, 1'b0);
      add_op(CMD_INSERT,  0,  32'h44444444, 1'b0);
      add_op(CMD_READ,    30, 32'h0,        1'b0);
      add_op(CMD_ERASE,   30, 32'h0,        1'b0);
      add_op(CMD_RESIZE,  5,  32'h0,        1'b0);
      wait_list_idle();

      foreach (cap_settings[p]) begin
         write_capacity(cap_settings[p]);
         // no idling in the closing stretch, and one quiet phase midway
         idling_on = (p < 8) && (p != 3);
         if (p == 5) long_hold_asks++;
         repeat (88) pending_list_ops.push_back(random_list_op(cap_settings[p]));
         wait_list_idle();
      end

      repeat (5) @(negedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/bvie_pkg.sv
hdl/bvie_cell.sv
hdl/bounded_vector_insert_erase.sv
bench/testbench.sv
